### design/hbh_pkg.sv
// Shared types, register indexes, fault codes and dwell limits for the
// heater band hysteresis controller. No dependencies.
package hbh_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // dwell thresholds in milliseconds
    localparam logic [31:0] ON_DWELL_OUTER_MS  = 32'd3000;
    localparam logic [31:0] OFF_DWELL_OUTER_MS = 32'd5000;
    localparam logic [31:0] ON_DWELL_INNER_MS  = 32'd2000;
    localparam logic [31:0] OFF_DWELL_INNER_MS = 32'd10000;

    // register reset values
    localparam logic [15:0] EVAL_INTERVAL_RST = 16'd1000;
    localparam logic [13:0] HIGH_LIMIT_RST    = 14'd9000;
    localparam logic [9:0]  COARSE_BAND_RST   = 10'd200;
    localparam logic [9:0]  FINE_BAND_RST     = 10'd40;
    localparam logic [15:0] HOLDOFF_RST       = 16'd30000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT      = 3'd0,
        REG_ENABLE        = 3'd1,
        REG_EVAL_INTERVAL = 3'd2,
        REG_HIGH_LIMIT    = 3'd3,
        REG_COARSE_BAND   = 3'd4,
        REG_FINE_BAND     = 3'd5,
        REG_HOLDOFF       = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        FAULT_NONE        = 2'd0,
        FAULT_DEAD_SENSOR = 2'd1,
        FAULT_OVERTEMP    = 2'd2
    } fault_t;

    typedef struct packed {
        logic [13:0] setpoint;
        logic        enable;
        logic [15:0] eval_interval;
        logic [13:0] high_limit;
        logic [9:0]  coarse_band;
        logic [9:0]  fine_band;
        logic [15:0] holdoff;
    } cfg_t;

    typedef struct packed {
        logic [31:0] last_eval_time;
        logic        eval_seen;
        logic [31:0] last_check_time;
        logic        check_seen;
        logic [31:0] on_dwell;
        logic [31:0] off_dwell;
        logic        heater;
        logic        pump;
        logic [31:0] last_notify_time;
        logic        notify_seen;
    } state_t;

    typedef struct packed {
        logic   evaluated;
        logic   heater_on;
        logic   pump_on;
        fault_t fault;
        logic   publish;
    } result_t;

endpackage

### design/hbh_cfg_regs.sv
// Configuration register file with write decode and the control-off
// refresh strobe. Depends on hbh_pkg.
module hbh_cfg_regs import hbh_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output logic                  refresh
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;

    assign idx = reg_idx_t'(cfg_index);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (idx)
                REG_SETPOINT:      cfg_next.setpoint      = cfg_data[13:0];
                REG_ENABLE:        cfg_next.enable        = cfg_data[0];
                REG_EVAL_INTERVAL: cfg_next.eval_interval = cfg_data;
                REG_HIGH_LIMIT:    cfg_next.high_limit    = cfg_data[13:0];
                REG_COARSE_BAND:   cfg_next.coarse_band   = cfg_data[9:0];
                REG_FINE_BAND:     cfg_next.fine_band     = cfg_data[9:0];
                REG_HOLDOFF:       cfg_next.holdoff       = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // writing setpoint or enable into an off condition clears the loop state
    assign refresh = cfg_wr_en && (idx == REG_SETPOINT || idx == REG_ENABLE) &&
                     (cfg_next.setpoint == 14'd0 || !cfg_next.enable);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint      <= 14'd0;
            cfg_reg.enable        <= 1'b0;
            cfg_reg.eval_interval <= EVAL_INTERVAL_RST;
            cfg_reg.high_limit    <= HIGH_LIMIT_RST;
            cfg_reg.coarse_band   <= COARSE_BAND_RST;
            cfg_reg.fine_band     <= FINE_BAND_RST;
            cfg_reg.holdoff       <= HOLDOFF_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/hbh_step.sv
// Combinational evaluation of one sample: interval gate, fault checks,
// notify holdoff, dwell update and band rule. Depends on hbh_pkg.
module hbh_step import hbh_pkg::*; (
    input  cfg_t               cfg,
    input  state_t             st,
    input  logic        [31:0] now_ms,
    input  logic signed [14:0] temperature_centi,
    output state_t             st_next,
    output result_t            res
);

    logic [31:0]        since_eval;
    logic [31:0]        since_notify;
    logic [31:0]        dt;
    logic [32:0]        on_sum;
    logic [32:0]        off_sum;
    logic [31:0]        on_dwell;
    logic [31:0]        off_dwell;
    logic signed [16:0] t_ext;
    logic signed [16:0] sp_ext;
    logic signed [16:0] coarse_edge;
    logic signed [16:0] fine_edge;
    logic               due;
    logic               dead;
    logic               over;
    logic               notify_ok;
    logic               ctrl_off;
    logic               heater_new;
    fault_t             fault;

    assign since_eval   = now_ms - st.last_eval_time;
    assign since_notify = now_ms - st.last_notify_time;
    assign due          = !st.eval_seen || (since_eval >= {16'd0, cfg.eval_interval});
    assign notify_ok    = !st.notify_seen || (since_notify >= {16'd0, cfg.holdoff});
    assign ctrl_off     = (cfg.setpoint == 14'd0) || !cfg.enable;

    assign t_ext       = {{2{temperature_centi[14]}}, temperature_centi};
    assign sp_ext      = $signed({3'd0, cfg.setpoint});
    assign coarse_edge = sp_ext - $signed({7'd0, cfg.coarse_band});
    assign fine_edge   = sp_ext - $signed({7'd0, cfg.fine_band});

    assign dead = temperature_centi[14] || (temperature_centi == 15'sd0);
    assign over = t_ext > $signed({3'd0, cfg.high_limit});

    always_comb begin
        if (dead) begin
            fault = FAULT_DEAD_SENSOR;
        end else if (over) begin
            fault = FAULT_OVERTEMP;
        end else begin
            fault = FAULT_NONE;
        end
    end

    // dwell of the current heater state grows by elapsed time, saturating
    assign dt      = now_ms - st.last_check_time;
    assign on_sum  = {1'b0, st.on_dwell} + {1'b0, dt};
    assign off_sum = {1'b0, st.off_dwell} + {1'b0, dt};

    always_comb begin
        on_dwell  = st.on_dwell;
        off_dwell = st.off_dwell;
        if (st.check_seen) begin
            if (st.heater) begin
                on_dwell  = on_sum[32] ? 32'hFFFF_FFFF : on_sum[31:0];
                off_dwell = 32'd0;
            end else begin
                off_dwell = off_sum[32] ? 32'hFFFF_FFFF : off_sum[31:0];
                on_dwell  = 32'd0;
            end
        end
    end

    // three-band rule
    always_comb begin
        heater_new = st.heater;
        if (t_ext < coarse_edge) begin
            heater_new = 1'b1;
        end else if (t_ext < fine_edge) begin
            if (on_dwell >= ON_DWELL_OUTER_MS) begin
                heater_new = 1'b0;
            end else if (off_dwell >= OFF_DWELL_OUTER_MS) begin
                heater_new = 1'b1;
            end
        end else if (t_ext < sp_ext) begin
            if (on_dwell >= ON_DWELL_INNER_MS) begin
                heater_new = 1'b0;
            end else if (off_dwell >= OFF_DWELL_INNER_MS) begin
                heater_new = 1'b1;
            end
        end else begin
            heater_new = 1'b0;
        end
    end

    always_comb begin
        st_next       = st;
        res.evaluated = 1'b0;
        res.fault     = FAULT_NONE;
        res.publish   = 1'b0;
        if (due) begin
            res.evaluated          = 1'b1;
            res.fault              = fault;
            st_next.last_eval_time = now_ms;
            st_next.eval_seen      = 1'b1;
            if (fault != FAULT_NONE) begin
                st_next.heater = 1'b0;
                st_next.pump   = 1'b0;
                if (notify_ok) begin
                    st_next.last_notify_time = now_ms;
                    st_next.notify_seen      = 1'b1;
                    res.publish              = 1'b1;
                end
            end else if (!ctrl_off) begin
                st_next.pump            = 1'b1;
                st_next.on_dwell        = on_dwell;
                st_next.off_dwell       = off_dwell;
                st_next.last_check_time = now_ms;
                st_next.check_seen      = 1'b1;
                st_next.heater          = heater_new;
            end
        end
        res.heater_on = st_next.heater;
        res.pump_on   = st_next.pump;
    end

endmodule

### design/heater_band_hysteresis_control.sv
// Top level of the heater band hysteresis controller: input register,
// loop state, result register. Depends on hbh_pkg, hbh_cfg_regs, hbh_step.
//
// Usage:
//  - Input channel (s_valid/s_ready): one transaction is one sample, a
//    wrapping millisecond timestamp and a signed centidegree temperature.
//  - Result channel (m_valid/m_ready): exactly one transaction per sample,
//    in order: evaluated flag, heater and pump drives after the sample,
//    fault code and the rate-limited publish_error pulse.
//  - Config port: cfg_wr_en/cfg_index/cfg_data, written in one cycle,
//    only while no sample is in flight. Indexes past the list are dropped.
//  - Timing: an accepted sample has its result registered once the result
//    register is free. Throughput is one sample per cycle while m_ready is
//    high; the limit is the single evaluate stage between the input
//    register and the result register, which also carries the loop state.
//  - Stall: when m_ready is low the result is held; one more sample may
//    wait in the input register, then s_ready drops until the result moves.
//  - Reset (aresetn low, synchronous): registers go to their documented
//    defaults, drives off, all timers and seen flags cleared, both
//    channels empty.
module heater_band_hysteresis_control import hbh_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // sample input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [31:0]           s_now_ms,
    input  logic signed [14:0]    s_temperature_centi,
    // result output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_evaluated,
    output logic                  m_heater_on,
    output logic                  m_pump_on,
    output logic [1:0]            m_fault_code,
    output logic                  m_publish_error
);

    cfg_t               cfg;
    logic               refresh;
    state_t             state_reg;
    state_t             state_next;
    result_t            res;
    result_t            res_reg;
    logic               in_vld_reg;
    logic [31:0]        now_reg;
    logic signed [14:0] temp_reg;
    logic               out_vld_reg;
    logic               fire;

    hbh_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .refresh   (refresh)
    );

    hbh_step u_step (
        .cfg               (cfg),
        .st                (state_reg),
        .now_ms            (now_reg),
        .temperature_centi (temp_reg),
        .st_next           (state_next),
        .res               (res)
    );

    // evaluate when a sample waits and the result slot is free or draining
    assign fire    = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg  <= s_now_ms;
            temp_reg <= s_temperature_centi;
        end
    end

    // loop state; user keeps refresh to idle (unenforced); it beats a sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (refresh) begin
            state_reg.heater          <= 1'b0;
            state_reg.pump            <= 1'b0;
            state_reg.eval_seen       <= 1'b0;
            state_reg.last_eval_time  <= 32'd0;
            state_reg.check_seen      <= 1'b0;
            state_reg.last_check_time <= 32'd0;
            state_reg.on_dwell        <= 32'd0;
            state_reg.off_dwell       <= 32'd0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (fire) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_evaluated     = res_reg.evaluated;
    assign m_heater_on     = res_reg.heater_on;
    assign m_pump_on       = res_reg.pump_on;
    assign m_fault_code    = res_reg.fault;
    assign m_publish_error = res_reg.publish;

    // heater never runs without the pump
    a_heater_needs_pump: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_heater_on || m_pump_on))
        else $error("heater on with pump off");

    // a fault forces both drives off
    a_fault_drives_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fault_code != FAULT_NONE) |-> (!m_heater_on && !m_pump_on))
        else $error("drive on during fault");

    // faults and publish only on evaluated samples, publish only with a fault
    a_publish_needs_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_publish_error) |-> (m_evaluated && m_fault_code != FAULT_NONE))
        else $error("publish without fault");

    a_fault_needs_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_evaluated) |-> (m_fault_code == FAULT_NONE))
        else $error("fault on skipped sample");

    // refresh leaves the loop idle with drives off
    a_refresh_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        refresh |=> (!state_reg.heater && !state_reg.pump && !state_reg.eval_seen))
        else $error("refresh did not clear loop state");

endmodule
